>>> src/sdc_pkg.sv
package sdc_pkg;

  typedef enum logic [1:0] {
    CMD_TO_DT  = 2'd0,
    CMD_TO_SEC = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       fval;
    logic       chk;
    logic [2:0] wdi;
  } side_t;

  localparam int NUM_STAGES = 9;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  localparam int SEC_MIN  = 60;
  localparam int SEC_HOUR = 3600;
  localparam int SEC_DAY  = 86400;
  localparam int DAYS_CYC = 1461;
  localparam int EPOCH_WD = 5;

  // floor(2^N / d) reciprocals; quotient comes out exact or one low
  localparam int RCP_DAY  = 25451658;  // 2^34 / 675, applied to seconds >> 7
  localparam int RCP_CYC  = 45933;     // 2^26 / 1461
  localparam int RCP_HOUR = 4660;      // 2^24 / 3600
  localparam int RCP_MIN  = 1092;      // 2^16 / 60
  localparam int RCP_WEEK = 149796;    // 2^20 / 7

  function automatic logic [10:0] year_start(input logic [1:0] k);
    case (k)
      2'd0:    year_start = 11'd0;
      2'd1:    year_start = 11'd366;
      2'd2:    year_start = 11'd731;
      default: year_start = 11'd1096;
    endcase
  endfunction

  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    if (leap && idx >= 4'd2 && idx <= 4'd11) begin
      v = v + 9'd1;
    end
    cum_days = v;
  endfunction

endpackage

>>> src/seconds_datetime_converter_core.sv
// Seconds / calendar converter, epoch at the start of year 2000, every fourth year leap.
// Input channel in_*: tuser selects the command (0 split seconds, 1 pack fields,
// 2 validate fields) plus the weekday-check flag; tdata carries the seconds and
// the date/time fields. Output channel out_*: tuser is ok, tdata carries packed
// seconds and the split date/time fields. One result leaves for every item.
// Throughput: one item per cycle unless a full pipeline meets out_tready low.
// Each item passes through the nine register stages (reciprocal multiply,
// remainder, correction for days, four-year cycles, hours and weekday, then
// year/month and minute split).
// Each stage holds a valid bit; a stage advances whenever the stage after it is
// empty or moving, so bubbles close up while out_tready is low and in_tready
// drops only once every stage is full. Nothing is lost or repeated on a stall.
// Reset (rst_n low, synchronous) empties the pipeline; only the valid bits are reset.
module seconds_datetime_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // seconds_in[31:0], year_in[39:32], month_in[43:40], day_in[48:44],
  // hour_in[53:49], minute_in[59:54], second_in[65:60], weekday_in[68:66]
  input  logic [sdc_pkg::IN_DATA_W-1:0] in_tdata,
  // cmd[1:0], check_weekday[2]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // seconds_out[31:0], year_out[39:32], month_out[43:40], day_out[48:44],
  // hour_out[53:49], minute_out[59:54], second_out[65:60], weekday_out[68:66]
  output logic [sdc_pkg::OUT_DATA_W-1:0] out_tdata,
  // ok[0]
  output logic        out_tuser
);

  localparam int NS = sdc_pkg::NUM_STAGES;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  sdc_pkg::side_t side_r [NS];
  sdc_pkg::side_t side_nxt;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side_nxt;
    end
    for (int i = 1; i < NS; i++) begin
      if (en[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ---------------- stage 0: day reciprocal, pack day count ----------------
  logic [31:0] sec_in;
  logic [7:0]  yr_in;
  logic [3:0]  mo_in;
  logic [4:0]  dy_in;
  logic [4:0]  hr_in;
  logic [5:0]  mi_in;
  logic [5:0]  se_in;
  logic [3:0]  mo_idx;
  logic        fval_nxt;
  logic [49:0] s0_p_nxt;
  logic [16:0] s0_d_nxt;
  logic [16:0] s0_ts_nxt;
  logic [31:0] s0_s_r;
  logic [49:0] s0_p_r;
  logic [16:0] s0_d_r;
  logic [16:0] s0_ts_r;

  assign sec_in = in_tdata[31:0];
  assign yr_in  = in_tdata[39:32];
  assign mo_in  = in_tdata[43:40];
  assign dy_in  = in_tdata[48:44];
  assign hr_in  = in_tdata[53:49];
  assign mi_in  = in_tdata[59:54];
  assign se_in  = in_tdata[65:60];
  assign mo_idx = mo_in - 4'd1;

  assign fval_nxt = (mo_in >= 4'd1) && (mo_in <= 4'd12) && (dy_in >= 5'd1) &&
                    (hr_in <= 5'd24) && (mi_in <= 6'd59) && (se_in <= 6'd59);

  always_comb begin
    side_nxt.cmd  = sdc_pkg::cmd_t'(in_tuser[1:0]);
    side_nxt.chk  = in_tuser[2];
    side_nxt.wdi  = in_tdata[68:66];
    side_nxt.fval = fval_nxt;
  end

  assign s0_p_nxt  = 50'(sec_in[31:7]) * 50'(sdc_pkg::RCP_DAY);
  assign s0_d_nxt  = 17'(yr_in[7:2]) * 17'(sdc_pkg::DAYS_CYC)
                   + 17'(sdc_pkg::year_start(yr_in[1:0]))
                   + 17'(sdc_pkg::cum_days(yr_in[1:0] == 2'd0, mo_idx))
                   + 17'(dy_in) - 17'd1;
  assign s0_ts_nxt = 17'(hr_in) * 17'(sdc_pkg::SEC_HOUR)
                   + 17'(mi_in) * 17'(sdc_pkg::SEC_MIN) + 17'(se_in);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_s_r  <= sec_in;
      s0_p_r  <= s0_p_nxt;
      s0_d_r  <= s0_d_nxt;
      s0_ts_r <= s0_ts_nxt;
    end
  end

  // ---------------- stage 1: day remainder, packed seconds ----------------
  logic [15:0] s1_q_nxt;
  logic [32:0] s1_r33;
  logic [16:0] s1_wd_nxt;
  logic [15:0] s1_q_r;
  logic [17:0] s1_r_r;
  logic [33:0] s1_t_r;
  logic [16:0] s1_wd_r;

  assign s1_q_nxt  = s0_p_r[49:34];
  assign s1_r33    = {1'b0, s0_s_r} - 33'(s1_q_nxt) * 33'(sdc_pkg::SEC_DAY);
  assign s1_wd_nxt = s0_d_r + 17'(s0_ts_r >= 17'(sdc_pkg::SEC_DAY));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_q_r  <= s1_q_nxt;
      s1_r_r  <= s1_r33[17:0];
      s1_t_r  <= 34'(s0_d_r) * 34'(sdc_pkg::SEC_DAY) + 34'(s0_ts_r);
      s1_wd_r <= s1_wd_nxt;
    end
  end

  // ---------------- stage 2: correct days and time of day ----------------
  logic        s1_hi;
  logic [16:0] s2_days_r;
  logic [16:0] s2_tod_r;
  logic [31:0] s2_sec_r;
  logic        s2_ovf_r;

  assign s1_hi = s1_r_r >= 18'(sdc_pkg::SEC_DAY);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (side_r[1].cmd == sdc_pkg::CMD_TO_DT) begin
        s2_days_r <= 17'(s1_q_r) + 17'(s1_hi);
      end else begin
        s2_days_r <= s1_wd_r;
      end
      s2_tod_r <= s1_hi ? 17'(s1_r_r - 18'(sdc_pkg::SEC_DAY)) : s1_r_r[16:0];
      s2_sec_r <= s1_t_r[31:0];
      s2_ovf_r <= s1_t_r[33:32] != 2'd0;
    end
  end

  // ---------------- stage 3: cycle, hour and week reciprocals ----------------
  logic [32:0] s3_cp;
  logic [29:0] s3_hp;
  logic [35:0] s3_wp;
  logic [16:0] s3_days_r;
  logic [16:0] s3_tod_r;
  logic [6:0]  s3_cq_r;
  logic [5:0]  s3_hq_r;
  logic [15:0] s3_wq_r;
  logic [31:0] s3_sec_r;
  logic        s3_ovf_r;

  assign s3_cp = 33'(s2_days_r) * 33'(sdc_pkg::RCP_CYC);
  assign s3_hp = 30'(s2_tod_r) * 30'(sdc_pkg::RCP_HOUR);
  assign s3_wp = (36'(s2_days_r) + 36'(sdc_pkg::EPOCH_WD)) * 36'(sdc_pkg::RCP_WEEK);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_days_r <= s2_days_r;
      s3_tod_r  <= s2_tod_r;
      s3_cq_r   <= s3_cp[32:26];
      s3_hq_r   <= s3_hp[29:24];
      s3_wq_r   <= s3_wp[35:20];
      s3_sec_r  <= s2_sec_r;
      s3_ovf_r  <= s2_ovf_r;
    end
  end

  // ---------------- stage 4: remainders ----------------
  logic [16:0] s4_c17;
  logic [16:0] s4_h17;
  logic [17:0] s4_w18;
  logic [6:0]  s4_cq_r;
  logic [11:0] s4_cr_r;
  logic [5:0]  s4_hq_r;
  logic [12:0] s4_hr_r;
  logic [3:0]  s4_wr_r;
  logic [31:0] s4_sec_r;
  logic        s4_ovf_r;

  assign s4_c17 = s3_days_r - 17'(s3_cq_r) * 17'(sdc_pkg::DAYS_CYC);
  assign s4_h17 = s3_tod_r - 17'(s3_hq_r) * 17'(sdc_pkg::SEC_HOUR);
  assign s4_w18 = 18'(s3_days_r) + 18'(sdc_pkg::EPOCH_WD) - 18'(s3_wq_r) * 18'd7;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_cq_r  <= s3_cq_r;
      s4_cr_r  <= s4_c17[11:0];
      s4_hq_r  <= s3_hq_r;
      s4_hr_r  <= s4_h17[12:0];
      s4_wr_r  <= s4_w18[3:0];
      s4_sec_r <= s3_sec_r;
      s4_ovf_r <= s3_ovf_r;
    end
  end

  // ---------------- stage 5: correct quotients ----------------
  logic        s5_chi;
  logic        s5_hhi;
  logic [6:0]  s5_cyc_r;
  logic [10:0] s5_crem_r;
  logic [4:0]  s5_hour_r;
  logic [11:0] s5_mrem_r;
  logic [2:0]  s5_wd_r;
  logic [31:0] s5_sec_r;
  logic        s5_ovf_r;

  assign s5_chi = s4_cr_r >= 12'(sdc_pkg::DAYS_CYC);
  assign s5_hhi = s4_hr_r >= 13'(sdc_pkg::SEC_HOUR);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_cyc_r  <= s4_cq_r + 7'(s5_chi);
      s5_crem_r <= s5_chi ? 11'(s4_cr_r - 12'(sdc_pkg::DAYS_CYC)) : s4_cr_r[10:0];
      s5_hour_r <= 5'(s4_hq_r + 6'(s5_hhi));
      s5_mrem_r <= s5_hhi ? 12'(s4_hr_r - 13'(sdc_pkg::SEC_HOUR)) : s4_hr_r[11:0];
      s5_wd_r   <= (s4_wr_r >= 4'd7) ? 3'(s4_wr_r - 4'd7) : s4_wr_r[2:0];
      s5_sec_r  <= s4_sec_r;
      s5_ovf_r  <= s4_ovf_r;
    end
  end

  // ---------------- stage 6: year in cycle, minute reciprocal ----------------
  logic [1:0]  s6_k;
  logic [22:0] s6_mp;
  logic [1:0]  s6_k_r;
  logic [8:0]  s6_doy_r;
  logic [7:0]  s6_yr_r;
  logic [5:0]  s6_mq_r;
  logic [11:0] s6_mrem_r;
  logic [4:0]  s6_hour_r;
  logic [2:0]  s6_wd_r;
  logic [31:0] s6_sec_r;
  logic        s6_ovf_r;

  always_comb begin
    if (s5_crem_r >= sdc_pkg::year_start(2'd3)) begin
      s6_k = 2'd3;
    end else if (s5_crem_r >= sdc_pkg::year_start(2'd2)) begin
      s6_k = 2'd2;
    end else if (s5_crem_r >= sdc_pkg::year_start(2'd1)) begin
      s6_k = 2'd1;
    end else begin
      s6_k = 2'd0;
    end
  end

  assign s6_mp = 23'(s5_mrem_r) * 23'(sdc_pkg::RCP_MIN);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_k_r    <= s6_k;
      s6_doy_r  <= 9'(s5_crem_r - sdc_pkg::year_start(s6_k));
      s6_yr_r   <= {s5_cyc_r[5:0], s6_k};
      s6_mq_r   <= s6_mp[21:16];
      s6_mrem_r <= s5_mrem_r;
      s6_hour_r <= s5_hour_r;
      s6_wd_r   <= s5_wd_r;
      s6_sec_r  <= s5_sec_r;
      s6_ovf_r  <= s5_ovf_r;
    end
  end

  // ---------------- stage 7: month search, minute remainder ----------------
  logic        s7_leap;
  logic [3:0]  s7_m;
  logic [11:0] s7_mr12;
  logic [3:0]  s7_mon_r;
  logic [4:0]  s7_day_r;
  logic [6:0]  s7_mr_r;
  logic [5:0]  s7_mq_r;
  logic [7:0]  s7_yr_r;
  logic [4:0]  s7_hour_r;
  logic [2:0]  s7_wd_r;
  logic [31:0] s7_sec_r;
  logic        s7_ovf_r;

  assign s7_leap = s6_k_r == 2'd0;

  always_comb begin
    s7_m = 4'd1;
    for (int i = 1; i < 12; i++) begin
      if (s6_doy_r >= sdc_pkg::cum_days(s7_leap, 4'(i))) begin
        s7_m = 4'(i + 1);
      end
    end
  end

  assign s7_mr12 = s6_mrem_r - 12'(s6_mq_r) * 12'(sdc_pkg::SEC_MIN);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_mon_r  <= s7_m;
      s7_day_r  <= 5'(s6_doy_r - sdc_pkg::cum_days(s7_leap, s7_m - 4'd1) + 9'd1);
      s7_mr_r   <= s7_mr12[6:0];
      s7_mq_r   <= s6_mq_r;
      s7_yr_r   <= s6_yr_r;
      s7_hour_r <= s6_hour_r;
      s7_wd_r   <= s6_wd_r;
      s7_sec_r  <= s6_sec_r;
      s7_ovf_r  <= s6_ovf_r;
    end
  end

  // ---------------- stage 8: result ----------------
  logic        s8_mhi;
  logic        ok_nxt;
  logic        dt_sel;
  logic        ok_r;
  logic [31:0] so_r;
  logic [7:0]  yo_r;
  logic [3:0]  mo_r;
  logic [4:0]  do_r;
  logic [4:0]  ho_r;
  logic [5:0]  mio_r;
  logic [5:0]  seo_r;
  logic [2:0]  wo_r;

  assign s8_mhi = s7_mr_r >= 7'(sdc_pkg::SEC_MIN);
  assign dt_sel = side_r[7].cmd == sdc_pkg::CMD_TO_DT;

  always_comb begin
    case (side_r[7].cmd)
      sdc_pkg::CMD_TO_DT:  ok_nxt = 1'b1;
      sdc_pkg::CMD_TO_SEC: ok_nxt = side_r[7].fval && !s7_ovf_r;
      sdc_pkg::CMD_CHECK:  ok_nxt = side_r[7].fval &&
                                    (!side_r[7].chk ||
                                     (side_r[7].wdi != 3'd7 && side_r[7].wdi == s7_wd_r));
      default:             ok_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      ok_r  <= ok_nxt;
      so_r  <= (side_r[7].cmd == sdc_pkg::CMD_TO_SEC && ok_nxt) ? s7_sec_r : 32'd0;
      yo_r  <= dt_sel ? s7_yr_r : 8'd0;
      mo_r  <= dt_sel ? s7_mon_r : 4'd0;
      do_r  <= dt_sel ? s7_day_r : 5'd0;
      ho_r  <= dt_sel ? s7_hour_r : 5'd0;
      mio_r <= dt_sel ? (s7_mq_r + 6'(s8_mhi)) : 6'd0;
      seo_r <= dt_sel ? 6'(s8_mhi ? s7_mr_r - 7'(sdc_pkg::SEC_MIN) : s7_mr_r) : 6'd0;
      wo_r  <= dt_sel ? s7_wd_r : 3'd0;
    end
  end

  assign out_tvalid = v_r[NS-1];
  assign out_tuser  = ok_r;
  assign out_tdata  = {3'd0, wo_r, seo_r, mio_r, ho_r, do_r, mo_r, yo_r, so_r};

endmodule

>>> src/sdc_checker.sv
module sdc_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [sdc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic        out_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  a_seconds_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31:0] != 32'd0 |-> out_tuser)
    else $error("packed seconds without ok");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[43:40] != 4'd0 |->
      out_tuser && out_tdata[43:40] <= 4'd12 && out_tdata[48:44] != 5'd0 &&
      out_tdata[53:49] <= 5'd23 && out_tdata[68:66] <= 3'd6)
    else $error("split date out of range");

  // input only backs up when the whole pipeline is full and the output stalls
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while pipeline can advance");

endmodule

bind seconds_datetime_converter_core sdc_port_props u_sdc_port_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
